// ===== hw/rtl/mer_pkg.sv =====
// Midpoint ellipse rasterizer: shared widths, codes, state encoding and
// the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package mer_pkg;

  localparam int RAD_W = 10;   // semi-axis register width
  localparam int PT_W  = 11;   // point coordinate width
  localparam int OX_W  = 11;   // x offset width
  localparam int OY_W  = 12;   // y offset width, signed
  localparam int SQ_W  = 20;   // squared semi-axis width
  localparam int DEC_W = 48;   // decision / accumulator width, signed
  localparam int MUL_W = 25;   // signed multiplier operand width

  // configuration register indexes
  localparam logic CFG_RADIUS_X = 1'b0;
  localparam logic CFG_RADIUS_Y = 1'b1;

  localparam logic [RAD_W-1:0] RADIUS_X_RST = RAD_W'(2);
  localparam logic [RAD_W-1:0] RADIUS_Y_RST = RAD_W'(3);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_R0, ST_R1, ST_R2, ST_R3,
    ST_CHK, ST_C1, ST_C2,
    ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5,
    ST_EMIT, ST_A1, ST_A2, ST_B1, ST_B2,
    ST_OUT
  } state_e;

  // datapath register update selects
  typedef enum logic [3:0] {
    DP_NOP,
    DP_INIT,      // offsets to top point, region one, clear done
    DP_LD_SQX,
    DP_LD_SQY,
    DP_LD_DEC0,   // dec = 4*b2 + a2*(1-4ry)
    DP_LD_T1,
    DP_SET_R2,
    DP_ACC_T1,    // t1 += 4*prod
    DP_SW_DEC,    // dec = t1 - 4*prod
    DP_HOLD_PTS,
    DP_HOLD_FIN,
    DP_A1,        // dec += 4*prod, x++
    DP_A2,        // dec -= 8*prod, y--
    DP_B1,        // dec -= 4*prod, y--
    DP_B2,        // dec += 8*prod, x++
    DP_OUT
  } dp_op_e;

  // multiplier operand pair selects
  typedef enum logic [3:0] {
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_A2_K0,    // a2 * (1 - 4ry)
    MUL_A2_TY1,   // a2 * (2y - 1)
    MUL_B2_XP1,   // b2 * (x + 1)
    MUL_TX1_SQ,   // (2x + 1)^2
    MUL_B2_P,     // b2 * prod
    MUL_YM1_SQ,   // (y - 1)^2
    MUL_A2_P,     // a2 * prod
    MUL_A2_B2,
    MUL_B2_TX3,   // b2 * (2x + 3)
    MUL_A2_YM1,   // a2 * (y - 1)
    MUL_A2_TY3    // a2 * (2y - 3)
  } mul_op_e;

  typedef struct packed {
    dp_op_e  op;
    mul_op_e mul;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic region;
    logic dec_neg;
    logic dec_pos;
    logic cmp_gt;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/mer_mul.sv =====
// Registered signed multiplier shared by all datapath products.
// Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_mul
  import mer_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [MUL_W-1:0] a_i,
  input  logic signed [MUL_W-1:0] b_i,
  output logic signed [DEC_W-1:0] prod_o
);

  logic signed [2*MUL_W-1:0] full;
  logic signed [DEC_W-1:0]   prod_q;

  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= full[DEC_W-1:0];
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/mer_dp.sv =====
// Datapath: semi-axis registers, offsets, squares, decision value,
// operand select for the shared multiplier, result hold and output word.
// Depends on mer_pkg and mer_mul.
`timescale 1ns / 1ps

module mer_dp
  import mer_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [RAD_W-1:0] cfg_data_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [PT_W-1:0] px_right_o,
  output logic [PT_W-1:0] px_left_o,
  output logic [PT_W-1:0] py_low_o,
  output logic [PT_W-1:0] py_high_o,
  output logic            points_valid_o,
  output logic            in_region_two_o,
  output logic            last_step_o,
  output logic            finished_o
);

  typedef int sint;

  logic [RAD_W-1:0]        rx_q, ry_q;
  logic [OX_W-1:0]         x_q;
  logic signed [OY_W-1:0]  y_q;
  logic [SQ_W-1:0]         sqx_q, sqy_q;
  logic signed [DEC_W-1:0] dec_q, t1_q;
  logic                    region_q, done_q;

  logic [PT_W-1:0]         hpr_q, hpl_q, hpyl_q, hpyh_q;
  logic                    hvalid_q, hregion_q, hfin_q;

  logic                    out_valid_q;
  logic [PT_W-1:0]         opr_q, opl_q, opyl_q, opyh_q;
  logic                    opv_q, oreg_q, olast_q, ofin_q;

  logic signed [MUL_W-1:0] op_a, op_b;
  logic signed [DEC_W-1:0] prod, prod2, prod4, prod8;

  logic [OX_W:0]           xp1, tx1;
  logic [OX_W+1:0]         tx3;
  logic signed [OY_W+1:0]  ty1, ty3;
  logic signed [OY_W:0]    ym1;
  logic signed [OY_W:0]    k0;
  logic                    last;
  logic                    out_load;

  mer_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  assign xp1 = {1'b0, x_q} + (OX_W+1)'(1);
  assign tx1 = {x_q, 1'b1};
  assign tx3 = {1'b0, x_q, 1'b1} + (OX_W+2)'(2);
  assign ty1 = $signed({y_q[OY_W-1], y_q, 1'b1}) - (OY_W+2)'(sint'(2));
  assign ty3 = $signed({y_q[OY_W-1], y_q, 1'b1}) - (OY_W+2)'(sint'(4));
  assign ym1 = $signed({y_q[OY_W-1], y_q}) - (OY_W+1)'(sint'(1));
  assign k0  = (OY_W+1)'(sint'(1)) - $signed({1'b0, ry_q, 2'b00});

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd_i.mul)
      MUL_RX_RX: begin
        op_a = MUL_W'(rx_q);
        op_b = MUL_W'(rx_q);
      end
      MUL_RY_RY: begin
        op_a = MUL_W'(ry_q);
        op_b = MUL_W'(ry_q);
      end
      MUL_A2_K0: begin
        op_a = MUL_W'(sqx_q);
        op_b = MUL_W'(k0);
      end
      MUL_A2_TY1: begin
        op_a = MUL_W'(sqx_q);
        op_b = MUL_W'(ty1);
      end
      MUL_B2_XP1: begin
        op_a = MUL_W'(sqy_q);
        op_b = MUL_W'(xp1);
      end
      MUL_TX1_SQ: begin
        op_a = MUL_W'(tx1);
        op_b = MUL_W'(tx1);
      end
      MUL_B2_P: begin
        op_a = MUL_W'(sqy_q);
        op_b = prod[MUL_W-1:0];
      end
      MUL_YM1_SQ: begin
        op_a = MUL_W'(ym1);
        op_b = MUL_W'(ym1);
      end
      MUL_A2_P: begin
        op_a = MUL_W'(sqx_q);
        op_b = prod[MUL_W-1:0];
      end
      MUL_A2_B2: begin
        op_a = MUL_W'(sqx_q);
        op_b = MUL_W'(sqy_q);
      end
      MUL_B2_TX3: begin
        op_a = MUL_W'(sqy_q);
        op_b = MUL_W'(tx3);
      end
      MUL_A2_YM1: begin
        op_a = MUL_W'(sqx_q);
        op_b = MUL_W'(ym1);
      end
      MUL_A2_TY3: begin
        op_a = MUL_W'(sqx_q);
        op_b = MUL_W'(ty3);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod2 = {prod[DEC_W-2:0], 1'b0};
  assign prod4 = {prod[DEC_W-3:0], 2'b00};
  assign prod8 = {prod[DEC_W-4:0], 3'b000};

  assign last     = hvalid_q & hregion_q & y_q[OY_W-1];
  assign out_load = (cmd_i.op == DP_OUT);

  // config and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q        <= RADIUS_X_RST;
      ry_q        <= RADIUS_Y_RST;
      region_q    <= 1'b0;
      done_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_RADIUS_X) begin
        rx_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_RADIUS_Y) begin
        ry_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        DP_INIT: begin
          region_q <= 1'b0;
          done_q   <= 1'b0;
        end
        DP_SET_R2: region_q <= 1'b1;
        DP_OUT:    done_q   <= done_q | last;
        default:   ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_INIT: begin
        x_q <= '0;
        y_q <= OY_W'(ry_q);
      end
      DP_LD_SQX:  sqx_q <= prod[SQ_W-1:0];
      DP_LD_SQY:  sqy_q <= prod[SQ_W-1:0];
      DP_LD_DEC0: dec_q <= DEC_W'({sqy_q, 2'b00}) + prod;
      DP_LD_T1:   t1_q  <= prod;
      DP_ACC_T1:  t1_q  <= t1_q + prod4;
      DP_SW_DEC:  dec_q <= t1_q - prod4;
      DP_HOLD_PTS: begin
        hpr_q     <= PT_W'(rx_q) + x_q;
        hpl_q     <= PT_W'(rx_q) - x_q;
        hpyl_q    <= PT_W'(ry_q) + y_q[PT_W-1:0];
        hpyh_q    <= PT_W'(ry_q) - y_q[PT_W-1:0];
        hvalid_q  <= 1'b1;
        hregion_q <= region_q;
        hfin_q    <= 1'b0;
      end
      DP_HOLD_FIN: begin
        hpr_q     <= '0;
        hpl_q     <= '0;
        hpyl_q    <= '0;
        hpyh_q    <= '0;
        hvalid_q  <= 1'b0;
        hregion_q <= 1'b0;
        hfin_q    <= 1'b1;
      end
      DP_A1: begin
        dec_q <= dec_q + prod4;
        x_q   <= x_q + OX_W'(1);
      end
      DP_A2: begin
        dec_q <= dec_q - prod8;
        y_q   <= y_q - OY_W'(1);
      end
      DP_B1: begin
        dec_q <= dec_q - prod4;
        y_q   <= y_q - OY_W'(1);
      end
      DP_B2: begin
        dec_q <= dec_q + prod8;
        x_q   <= x_q + OX_W'(1);
      end
      DP_OUT: begin
        opr_q   <= hpr_q;
        opl_q   <= hpl_q;
        opyl_q  <= hpyl_q;
        opyh_q  <= hpyh_q;
        opv_q   <= hvalid_q;
        oreg_q  <= hregion_q;
        olast_q <= last;
        ofin_q  <= hfin_q;
      end
      default: ;
    endcase
  end

  assign sts_o.done     = done_q;
  assign sts_o.region   = region_q;
  assign sts_o.dec_neg  = dec_q[DEC_W-1];
  assign sts_o.dec_pos  = !dec_q[DEC_W-1] && (dec_q != '0);
  assign sts_o.cmp_gt   = (t1_q > prod2);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign px_right_o      = opr_q;
  assign px_left_o       = opl_q;
  assign py_low_o        = opyl_q;
  assign py_high_o       = opyh_q;
  assign points_valid_o  = opv_q;
  assign in_region_two_o = oreg_q;
  assign last_step_o     = olast_q;
  assign finished_o      = ofin_q;

`ifndef NO_ASSERTIONS
  a_fin_no_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ofin_q |-> !opv_q && !olast_q)
    else $error("finished word carries points");

  a_last_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && last |=> done_q)
    else $error("done not set after last point group");
`endif

endmodule

// ===== hw/rtl/mer_ctrl.sv =====
// Controller: sequences restart setup, region test, region switch and
// decision update through the shared multiplier, one product per cycle unless the output stalls.
// Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_ctrl
  import mer_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic restart_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = restart_i ? ST_R0 : ST_CHK;
        end
      end
      ST_R0: state_d = ST_R1;
      ST_R1: state_d = ST_R2;
      ST_R2: state_d = ST_R3;
      ST_R3: state_d = ST_CHK;
      ST_CHK: begin
        priority if (sts_i.done) begin
          state_d = ST_OUT;
        end else if (!sts_i.region) begin
          state_d = ST_C1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_C1: state_d = ST_C2;
      ST_C2: state_d = sts_i.cmp_gt ? ST_EMIT : ST_W0;
      ST_W0: state_d = ST_W1;
      ST_W1: state_d = ST_W2;
      ST_W2: state_d = ST_W3;
      ST_W3: state_d = ST_W4;
      ST_W4: state_d = ST_W5;
      ST_W5: state_d = ST_EMIT;
      ST_EMIT: state_d = sts_i.region ? ST_B1 : ST_A1;
      ST_A1: state_d = sts_i.dec_neg ? ST_OUT : ST_A2;
      ST_A2: state_d = ST_OUT;
      ST_B1: state_d = sts_i.dec_pos ? ST_OUT : ST_B2;
      ST_B2: state_d = ST_OUT;
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op  = DP_NOP;
    cmd_o.mul = MUL_RX_RX;
    unique case (state_q)
      ST_IDLE: ;
      ST_R0: begin
        cmd_o.op  = DP_INIT;
        cmd_o.mul = MUL_RX_RX;
      end
      ST_R1: begin
        cmd_o.op  = DP_LD_SQX;
        cmd_o.mul = MUL_RY_RY;
      end
      ST_R2: begin
        cmd_o.op  = DP_LD_SQY;
        cmd_o.mul = MUL_A2_K0;
      end
      ST_R3: cmd_o.op = DP_LD_DEC0;
      ST_CHK: begin
        if (sts_i.done) begin
          cmd_o.op = DP_HOLD_FIN;
        end
        cmd_o.mul = MUL_A2_TY1;
      end
      ST_C1: begin
        cmd_o.op  = DP_LD_T1;
        cmd_o.mul = MUL_B2_XP1;
      end
      ST_C2: ;
      ST_W0: begin
        cmd_o.op  = DP_SET_R2;
        cmd_o.mul = MUL_TX1_SQ;
      end
      ST_W1: cmd_o.mul = MUL_B2_P;
      ST_W2: begin
        cmd_o.op  = DP_LD_T1;
        cmd_o.mul = MUL_YM1_SQ;
      end
      ST_W3: cmd_o.mul = MUL_A2_P;
      ST_W4: begin
        cmd_o.op  = DP_ACC_T1;
        cmd_o.mul = MUL_A2_B2;
      end
      ST_W5: cmd_o.op = DP_SW_DEC;
      ST_EMIT: begin
        cmd_o.op  = DP_HOLD_PTS;
        cmd_o.mul = sts_i.region ? MUL_A2_TY3 : MUL_B2_TX3;
      end
      ST_A1: begin
        cmd_o.op  = DP_A1;
        cmd_o.mul = MUL_A2_YM1;   // uses y before decrement, i.e. new y
      end
      ST_A2: cmd_o.op = DP_A2;
      ST_B1: begin
        cmd_o.op  = DP_B1;
        cmd_o.mul = MUL_B2_XP1;   // x still old here
      end
      ST_B2: cmd_o.op = DP_B2;
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_OUT;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_restart_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i |=> state_q == ST_R0)
    else $error("restart word did not enter setup");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && !sts_i.out_free |=> state_q == ST_OUT)
    else $error("result dropped while output stalled");
`endif

endmodule

// ===== hw/rtl/midpoint_ellipse_rasterizer.sv =====
// Midpoint ellipse rasterizer top level: controller plus datapath.
// Depends on mer_pkg, mer_ctrl, mer_dp (and mer_mul below it).
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  in      | in_valid_i / in_stall_o    | restart_i
//  out     | out_valid_o / out_stall_i  | px_right_o px_left_o py_low_o
//          |                            | py_high_o points_valid_o
//          |                            | in_region_two_o last_step_o finished_o
//  cfg     | cfg_we_i (no wait)         | cfg_idx_i cfg_data_i
//
// One word at a time: a finished word goes straight to the output; a step
// adds W0..W5 when it switches region, and a restart runs R0..R3 first.
// Each step is a chain of products through one shared registered multiplier.
// The next word is taken the cycle after the result enters the output register.
// Reset: idle and finished until a restart word; radii 2 and 3.
// A stalled output holds its word; a new word is taken meanwhile.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer
  import mer_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [RAD_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PT_W-1:0]  px_right_o,
  output logic [PT_W-1:0]  px_left_o,
  output logic [PT_W-1:0]  py_low_o,
  output logic [PT_W-1:0]  py_high_o,
  output logic             points_valid_o,
  output logic             in_region_two_o,
  output logic             last_step_o,
  output logic             finished_o
);

  cmd_t cmd;
  sts_t sts;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mer_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .px_right_o      (px_right_o),
    .px_left_o       (px_left_o),
    .py_low_o        (py_low_o),
    .py_high_o       (py_high_o),
    .points_valid_o  (points_valid_o),
    .in_region_two_o (in_region_two_o),
    .last_step_o     (last_step_o),
    .finished_o      (finished_o)
  );

endmodule
